### sv/dvna_pkg.sv
// Shared types and constants for the decaying vector nearest-anchor block.
// Anchor and delta tables in Q1.15, fixed-point decay constants, FSM codes.
// No dependencies; compile first.
package dvna_pkg;

    typedef logic signed [15:0] t_q15;
    typedef logic [3:0]         t_class;
    typedef logic [3:0]         t_event;

    localparam int unsigned TAB_DEPTH = 16;
    localparam int unsigned MUL_W     = 32;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_EVENT = 1'b1;

    localparam t_event WAKE_EVENT = 4'd5;

    // Decay: v' = round(v * (SPAN - t) / SPAN), ties away from zero
    localparam logic [14:0] DECAY_SPAN  = 15'd20000;
    localparam logic [13:0] DECAY_HALF  = 14'd10000;
    // floor(2^45 / 20000); quotient estimate is exact or one low
    localparam logic [30:0] RECIP_M     = 31'd1759218604;
    localparam int unsigned RECIP_SHIFT = 45;

    // Hysteresis margin, 0.008 in Q2.30
    localparam logic [33:0] HYST_Q30 = 34'd8589935;

    localparam t_q15 ANCHOR_V [TAB_DEPTH] = '{
        16'sd0, 16'sd22938, 16'sd9830, 16'sd3277, -16'sd16384, 16'sd0, 16'sd6554,
        -16'sd19661, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
    };
    localparam t_q15 ANCHOR_A [TAB_DEPTH] = '{
        16'sd0, 16'sd13107, 16'sd16384, 16'sd22938, 16'sd6554, -16'sd26214, 16'sd29491,
        -16'sd13107, 16'sd26214, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
    };
    localparam t_q15 DELTA_V [TAB_DEPTH] = '{
        16'sd13107, 16'sd19661, 16'sd3277, 16'sd6554, 16'sd0, 16'sd3277, -16'sd26214,
        -16'sd11469, -16'sd16384, 16'sd4915, 16'sd6554, 16'sd22938, 16'sd29491,
        16'sd0, 16'sd0, 16'sd0
    };
    localparam t_q15 DELTA_A [TAB_DEPTH] = '{
        16'sd6554, 16'sd9830, 16'sd16384, 16'sd9830, -16'sd26214, 16'sd9830, 16'sd29491,
        -16'sd9830, 16'sd26214, 16'sd13107, 16'sd3277, 16'sd9830, 16'sd4915,
        16'sd0, 16'sd0, 16'sd0
    };

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DECAY = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

endpackage

### sv/dvna_req_if.sv
// Request channel: valid/ready handshake carrying one tick or event word.
// Depends on dvna_pkg.
interface dvna_req_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [15:0]         elapsed_ms;
    dvna_pkg::t_event    event_code;

    modport source (output valid, output req_type, output elapsed_ms, output event_code,
                    input ready);
    modport sink   (input valid, input req_type, input elapsed_ms, input event_code,
                    output ready);
endinterface

### sv/dvna_rsp_if.sv
// Result channel: valid/ready handshake carrying class and vector words.
// Depends on dvna_pkg.
interface dvna_rsp_if;
    logic                valid;
    logic                ready;
    dvna_pkg::t_class    class_index;
    logic                class_changed;
    dvna_pkg::t_q15      valence_out;
    dvna_pkg::t_q15      activation_out;

    modport source (output valid, output class_index, output class_changed,
                    output valence_out, output activation_out, input ready);
    modport sink   (input valid, input class_index, input class_changed,
                    input valence_out, input activation_out, output ready);
endinterface

### sv/dvna_cfg_if.sv
// Configuration write channel: valid/ready carrying the initial_class word.
// Depends on dvna_pkg.
interface dvna_cfg_if;
    logic                valid;
    logic                ready;
    dvna_pkg::t_class    initial_class;

    modport source (output valid, output initial_class, input ready);
    modport sink   (input valid, input initial_class, output ready);
endinterface

### sv/dvna_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on dvna_pkg for the operand width.
module dvna_mul (
    input  logic                             i_clk,
    input  logic [dvna_pkg::MUL_W-1:0]       i_a,
    input  logic [dvna_pkg::MUL_W-1:0]       i_b,
    output logic [2*dvna_pkg::MUL_W-1:0]     o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

### sv/decaying_vector_nearest_anchor.sv
// Decaying (valence, activation) vector with nearest-anchor classification.
// A tick decays both components, then scans the anchors; an applied event only scans;
// a wake or ignored event goes straight to the result. One item is in flight at a
// time. The single 32x32 multiplier serves both phases: three multiplies per component
// for the decay, two squares per anchor for the scan.
// Reset (synchronous, active low) seeds vector and class from anchor 0, output empty.
// Depends on dvna_pkg, dvna_req_if, dvna_rsp_if, dvna_cfg_if and dvna_mul.
module decaying_vector_nearest_anchor #(
    parameter int NUM_ANCHORS = 9,   // 2..16
    parameter int NUM_EVENTS  = 13   // 1..16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dvna_req_if.sink         i_req,
    dvna_rsp_if.source       o_rsp,
    dvna_cfg_if.sink         i_cfg
);
    // Scan counter runs over 2*NUM_ANCHORS multiplies plus a final drain step
    localparam int CNT_W = $clog2(2 * NUM_ANCHORS + 1);
    localparam logic [CNT_W-1:0] SCAN_LAST  = CNT_W'(2 * NUM_ANCHORS);
    localparam logic [4:0]       N_ANCH_W   = 5'(NUM_ANCHORS);
    localparam logic [4:0]       N_EVT_W    = 5'(NUM_EVENTS);
    localparam int               MW         = dvna_pkg::MUL_W;
    localparam int               QLO        = dvna_pkg::RECIP_SHIFT;

    // Magnitude of a 17-bit signed value
    function automatic logic [16:0] mag17(input logic signed [16:0] x);
        logic signed [16:0] nx;
        nx = -x;
        return x[16] ? 17'(nx) : 17'(x);
    endfunction

    // Saturating Q1.15 add
    function automatic dvna_pkg::t_q15 sat_add(input dvna_pkg::t_q15 a,
                                               input dvna_pkg::t_q15 b);
        logic signed [16:0] s;
        s = 17'(a) + 17'(b);
        if (s > 17'sd32767) begin
            return 16'sd32767;
        end else if (s < -17'sd32768) begin
            return -16'sd32768;
        end
        return s[15:0];
    endfunction

    dvna_pkg::t_state     r_state;
    dvna_pkg::t_q15       r_val;
    dvna_pkg::t_q15       r_act;
    dvna_pkg::t_class     r_class;

    // Decay sequencer
    logic [2:0]           r_dstep;
    logic                 r_comp;       // 0 = valence, 1 = activation
    logic [14:0]          r_keep;
    logic [29:0]          r_x;
    logic [15:0]          r_q;

    // Scan sequencer
    logic [CNT_W-1:0]     r_mcnt;
    logic [32:0]          r_acc;
    dvna_pkg::t_class     r_best;
    logic [33:0]          r_best_d2;
    logic [33:0]          r_cur_d2;
    logic                 r_skip;       // no classification for this word

    // Output register
    logic                 r_out_valid;
    dvna_pkg::t_class     r_out_class;
    logic                 r_out_changed;
    dvna_pkg::t_q15       r_out_val;
    dvna_pkg::t_q15       r_out_act;

    logic [MW-1:0]        mul_a;
    logic [MW-1:0]        mul_b;
    logic [2*MW-1:0]      r_prod;

    dvna_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (r_prod)
    );

    logic                 req_acc;
    logic                 out_free;
    dvna_pkg::t_q15       comp_v;
    logic [16:0]          comp_mag;
    dvna_pkg::t_class     iss_idx;
    dvna_pkg::t_class     use_idx;
    logic [CNT_W-1:0]     use_k;
    logic signed [16:0]   dv;
    logic signed [16:0]   da;
    logic [33:0]          d2;
    logic [29:0]          rem;
    logic [15:0]          qf;
    logic [15:0]          qneg;
    logic [15:0]          n_comp;
    logic                 n_switch;
    dvna_pkg::t_class     n_class;
    dvna_pkg::t_class     seed_cls;
    logic [14:0]          tick_keep;

    assign i_req.ready = (r_state == dvna_pkg::ST_IDLE);
    // Take a configuration word only while idle with no request waiting
    assign i_cfg.ready = (r_state == dvna_pkg::ST_IDLE) && !i_req.valid;
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.class_index    = r_out_class;
    assign o_rsp.class_changed  = r_out_changed;
    assign o_rsp.valence_out    = r_out_val;
    assign o_rsp.activation_out = r_out_act;

    // Component under decay and its magnitude
    assign comp_v   = r_comp ? r_act : r_val;
    assign comp_mag = mag17(17'(comp_v));

    // Scan: issue multiply r_mcnt, consume multiply r_mcnt-1
    assign iss_idx = 4'(r_mcnt >> 1);
    assign use_k   = r_mcnt - CNT_W'(1);
    assign use_idx = 4'(use_k >> 1);
    assign dv      = 17'(r_val) - 17'(dvna_pkg::ANCHOR_V[iss_idx]);
    assign da      = 17'(r_act) - 17'(dvna_pkg::ANCHOR_A[iss_idx]);
    assign d2      = {1'b0, r_acc} + {1'b0, r_prod[32:0]};

    // Decay finish: correct the reciprocal estimate, restore sign
    assign rem    = r_x - r_prod[29:0];
    assign qf     = r_q + 16'(rem >= 30'(dvna_pkg::DECAY_SPAN));
    assign qneg   = -qf;
    assign n_comp = comp_v[15] ? qneg : qf;

    assign tick_keep = (i_req.elapsed_ms >= 16'(dvna_pkg::DECAY_SPAN)) ? 15'd0 :
                       15'(16'(dvna_pkg::DECAY_SPAN) - i_req.elapsed_ms);

    // Hysteresis: switch only if the best anchor wins by more than the margin
    assign n_switch = !r_skip && (r_best != r_class) &&
                      (({1'b0, r_best_d2} + {1'b0, dvna_pkg::HYST_Q30}) < {1'b0, r_cur_d2});
    assign n_class  = n_switch ? r_best : r_class;

    // Out-of-range initial class seeds anchor 0
    assign seed_cls = ({1'b0, i_cfg.initial_class} >= N_ANCH_W) ? 4'd0 : i_cfg.initial_class;

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            dvna_pkg::ST_DECAY: begin
                case (r_dstep)
                    3'd0: begin
                        mul_a = MW'(comp_mag);
                        mul_b = MW'(r_keep);
                    end
                    3'd2: begin
                        mul_a = MW'(r_x);
                        mul_b = MW'(dvna_pkg::RECIP_M);
                    end
                    3'd4: begin
                        mul_a = MW'(r_q);
                        mul_b = MW'(dvna_pkg::DECAY_SPAN);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            dvna_pkg::ST_SCAN: begin
                if (r_mcnt < SCAN_LAST) begin
                    mul_a = r_mcnt[0] ? MW'(mag17(da)) : MW'(mag17(dv));
                    mul_b = mul_a;
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dvna_pkg::ST_IDLE;
            r_val       <= dvna_pkg::ANCHOR_V[0];
            r_act       <= dvna_pkg::ANCHOR_A[0];
            r_class     <= '0;
            r_out_valid <= 1'b0;
            r_dstep     <= '0;
            r_comp      <= 1'b0;
            r_mcnt      <= '0;
            r_skip      <= 1'b0;
        end else begin
            // Drop the result word once taken, unless a new one loads now
            if (r_out_valid && o_rsp.ready && (r_state != dvna_pkg::ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                dvna_pkg::ST_IDLE: begin
                    if (req_acc) begin
                        r_dstep <= '0;
                        r_comp  <= 1'b0;
                        r_mcnt  <= '0;
                        if (i_req.req_type == dvna_pkg::REQ_TICK) begin
                            r_skip  <= 1'b0;
                            r_keep  <= tick_keep;
                            r_state <= dvna_pkg::ST_DECAY;
                        end else if ({1'b0, i_req.event_code} >= N_EVT_W) begin
                            // Ignored event: report state unchanged
                            r_skip  <= 1'b1;
                            r_state <= dvna_pkg::ST_FIN;
                        end else if (i_req.event_code == dvna_pkg::WAKE_EVENT) begin
                            r_val   <= dvna_pkg::ANCHOR_V[0];
                            r_act   <= dvna_pkg::ANCHOR_A[0];
                            r_class <= '0;
                            r_skip  <= 1'b1;
                            r_state <= dvna_pkg::ST_FIN;
                        end else begin
                            r_skip  <= 1'b0;
                            r_val   <= sat_add(r_val, dvna_pkg::DELTA_V[i_req.event_code]);
                            r_act   <= sat_add(r_act, dvna_pkg::DELTA_A[i_req.event_code]);
                            r_state <= dvna_pkg::ST_SCAN;
                        end
                    end
                end

                dvna_pkg::ST_DECAY: begin
                    r_dstep <= (r_dstep == 3'd5) ? 3'd0 : r_dstep + 3'd1;
                    case (r_dstep)
                        3'd1: r_x <= r_prod[29:0] + 30'(dvna_pkg::DECAY_HALF);
                        3'd3: r_q <= r_prod[QLO+15:QLO];
                        3'd5: begin
                            if (r_comp) begin
                                r_act   <= $signed(n_comp);
                                r_state <= dvna_pkg::ST_SCAN;
                            end else begin
                                r_val  <= $signed(n_comp);
                                r_comp <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                dvna_pkg::ST_SCAN: begin
                    r_mcnt <= r_mcnt + CNT_W'(1);
                    if (r_mcnt != '0) begin
                        if (!use_k[0]) begin
                            r_acc <= r_prod[32:0];
                        end else begin
                            // Lowest index wins ties: replace only on strictly less
                            if (use_idx == '0 || d2 < r_best_d2) begin
                                r_best    <= use_idx;
                                r_best_d2 <= d2;
                            end
                            if (use_idx == r_class) begin
                                r_cur_d2 <= d2;
                            end
                        end
                    end
                    if (r_mcnt == SCAN_LAST) begin
                        r_state <= dvna_pkg::ST_FIN;
                    end
                end

                dvna_pkg::ST_FIN: begin
                    // Hold until the output register can take the word
                    if (out_free) begin
                        r_class       <= n_class;
                        r_out_valid   <= 1'b1;
                        r_out_class   <= n_class;
                        r_out_changed <= n_switch;
                        r_out_val     <= r_val;
                        r_out_act     <= r_act;
                        r_state       <= dvna_pkg::ST_IDLE;
                    end
                end

                default: begin
                    r_state <= dvna_pkg::ST_IDLE;
                end
            endcase

            // Configuration write re-seeds vector and class
            if (i_cfg.valid && i_cfg.ready) begin
                r_val   <= dvna_pkg::ANCHOR_V[seed_cls];
                r_act   <= dvna_pkg::ANCHOR_A[seed_cls];
                r_class <= seed_cls;
            end
        end
    end

endmodule

### sv/dvna_chk.sv
// Port-level checker for decaying_vector_nearest_anchor, bound to the top level.
// Depends on dvna_pkg types only through the bound ports.
module dvna_chk #(
    parameter int NUM_ANCHORS = 9
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [3:0]  i_rsp_class,
    input logic        i_rsp_changed,
    input logic [15:0] i_rsp_val
);
    localparam logic [4:0] N_ANCH_W = 5'(NUM_ANCHORS);

    // Result word holds while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_class)
            && $stable(i_rsp_changed) && $stable(i_rsp_val))
        else $error("result word changed while stalled");

    // Output register comes up empty after reset
    a_rsp_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // One word in flight: not ready the cycle after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // Reported class is always a real anchor
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> {1'b0, i_rsp_class} < N_ANCH_W)
        else $error("class index out of range");

endmodule

bind decaying_vector_nearest_anchor dvna_chk #(.NUM_ANCHORS(NUM_ANCHORS)) u_dvna_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_class   (o_rsp.class_index),
    .i_rsp_changed (o_rsp.class_changed),
    .i_rsp_val     (o_rsp.valence_out)
);

### sim/tb_decaying_vector_nearest_anchor.sv
// Testbench for decaying_vector_nearest_anchor: a directed table of ticks and events,
// then random phases under several initial_class settings, checked word by word.
// Depends on dvna_pkg and the dvna_req_if, dvna_rsp_if and dvna_cfg_if interfaces.
module tb_decaying_vector_nearest_anchor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ANCHORS     = 9;
    localparam int NUM_EVENTS      = 13;
    localparam int SPAN            = 20000;         // full decay window, ms
    localparam longint MARGIN_Q30  = 64'd8589935;   // 0.008 in Q2.30
    localparam int Q15_MAX         = 32767;
    localparam int Q15_MIN         = -32768;
    localparam int MAX_GAP         = 17;
    localparam int LONG_HOLD       = 200;           // receiver hold-off under pressure
    localparam int SETTLE          = 40;            // slowest item is a tick
    localparam int IDLE_LIMIT      = 4000;          // cycles with no handshake at all
    localparam int WORDS_PER_PHASE = 150;

    localparam dvna_pkg::t_event EV_LAST       = dvna_pkg::t_event'(NUM_EVENTS - 1);
    localparam dvna_pkg::t_event EV_IGNORED_LO = dvna_pkg::t_event'(NUM_EVENTS);
    localparam dvna_pkg::t_event EV_IGNORED_HI = 4'd15;

    localparam logic KNOWN   = 1'b1;   // row carries its expected word
    localparam logic PREDICT = 1'b0;   // row is checked against the predictor

    localparam logic REQ_TICK  = dvna_pkg::REQ_TICK;
    localparam logic REQ_EVENT = dvna_pkg::REQ_EVENT;
    localparam dvna_pkg::t_event WAKE_EVENT = dvna_pkg::WAKE_EVENT;

    // Anchors and event steps, Q1.15
    localparam int ANCH_V [NUM_ANCHORS] =
        '{0, 22938, 9830, 3277, -16384, 0, 6554, -19661, -16384};
    localparam int ANCH_A [NUM_ANCHORS] =
        '{0, 13107, 16384, 22938, 6554, -26214, 29491, -13107, 26214};
    localparam int STEP_V [NUM_EVENTS] =
        '{13107, 19661, 3277, 6554, 0, 3277, -26214, -11469, -16384, 4915, 6554, 22938, 29491};
    localparam int STEP_A [NUM_EVENTS] =
        '{6554, 9830, 16384, 9830, -26214, 9830, 29491, -9830, 26214, 13107, 3277, 9830, 4915};

    typedef struct packed {
        dvna_pkg::t_class cls;
        logic             changed;
        dvna_pkg::t_q15   val;
        dvna_pkg::t_q15   act;
    } t_mood_word;

    typedef struct packed {
        logic             kind;
        logic [15:0]      ms;
        dvna_pkg::t_event ev;
        logic             known;
        t_mood_word       want;
    } t_stim_row;

    localparam t_mood_word REST = '0;   // class 0, no change, vector at the origin

    // Directed part: the rest state, ignored codes, both saturation rails, wake,
    // and the decay extremes. Rows after a wake start from the origin again.
    localparam t_stim_row DIRECTED [26] = '{
        '{REQ_TICK,  16'd0,     4'd0,          KNOWN,   REST},
        '{REQ_EVENT, 16'd0,     EV_IGNORED_LO, KNOWN,   REST},
        '{REQ_EVENT, 16'hFFFF,  EV_IGNORED_HI, KNOWN,   REST},
        '{REQ_TICK,  16'hFFFF,  4'd0,          KNOWN,   REST},
        '{REQ_EVENT, 16'd0,     4'd0,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     EV_LAST,       PREDICT, REST},
        '{REQ_EVENT, 16'd0,     EV_LAST,       PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd11,         PREDICT, REST},
        '{REQ_TICK,  16'd1,     4'd0,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd1,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd2,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd3,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd9,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd10,         PREDICT, REST},
        '{REQ_TICK,  16'd10000, 4'd0,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd6,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd6,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd8,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd7,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd7,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd4,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd4,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     4'd4,          PREDICT, REST},
        '{REQ_EVENT, 16'd0,     WAKE_EVENT,    KNOWN,   REST},
        '{REQ_TICK,  16'd20000, 4'd0,          KNOWN,   REST},
        '{REQ_TICK,  16'd19999, 4'd0,          KNOWN,   REST}
    };

    // Initial class per phase: both ends of the range, out-of-range codes and the rest
    localparam dvna_pkg::t_class CLASS_PLAN [12] =
        '{4'd8, 4'd15, 4'd3, 4'd0, 4'd9, 4'd1, 4'd6, 4'd4, 4'd7, 4'd2, 4'd5, 4'd12};

    logic i_clk = 1'b0;
    logic i_rst_n;

    dvna_req_if req_if ();
    dvna_rsp_if rsp_if ();
    dvna_cfg_if cfg_if ();

    decaying_vector_nearest_anchor #(
        .NUM_ANCHORS (NUM_ANCHORS),
        .NUM_EVENTS  (NUM_EVENTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: the vector and the class
    dvna_pkg::t_q15   mood_val;
    dvna_pkg::t_q15   mood_act;
    dvna_pkg::t_class mood_cls;

    t_mood_word mood_expected [$];   // expected words, oldest first

    int  err_count   = 0;
    int  words_seen  = 0;
    int  idle_cycles = 0;
    bit  tx_burst    = 1'b0;   // sender runs without gaps while set
    bit  tx_flood    = 1'b0;   // pressure: sender offers words back to back
    bit  hold_results = 1'b0;  // pressure: receiver takes one long hold-off

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic dvna_pkg::t_q15 sat_q15(int x);
        if (x > Q15_MAX) return dvna_pkg::t_q15'(Q15_MAX);
        if (x < Q15_MIN) return dvna_pkg::t_q15'(Q15_MIN);
        return dvna_pkg::t_q15'(x);
    endfunction

    // Scale by keep/SPAN, rounding to nearest with ties away from zero
    function automatic dvna_pkg::t_q15 decay_q15(dvna_pkg::t_q15 x, int keep);
        longint prod;
        longint mag;
        longint q;
        prod = longint'(x) * keep;
        mag  = (prod < 0) ? -prod : prod;
        q    = (mag + SPAN / 2) / SPAN;
        return dvna_pkg::t_q15'((prod < 0) ? -q : q);
    endfunction

    function automatic longint anchor_d2(int idx);
        longint dv;
        longint da;
        dv = longint'(mood_val) - ANCH_V[idx];
        da = longint'(mood_act) - ANCH_A[idx];
        return dv * dv + da * da;
    endfunction

    // Nearest anchor, lowest index on ties; switch only past the hysteresis margin
    function automatic logic reclassify();
        longint cur_d2;
        longint best_d2;
        longint d2;
        int     best;
        cur_d2  = anchor_d2(int'(mood_cls));
        best    = 0;
        best_d2 = anchor_d2(0);
        for (int i = 1; i < NUM_ANCHORS; i++) begin
            d2 = anchor_d2(i);
            if (d2 < best_d2) begin
                best_d2 = d2;
                best    = i;
            end
        end
        if (best != int'(mood_cls) && best_d2 + MARGIN_Q30 < cur_d2) begin
            mood_cls = dvna_pkg::t_class'(best);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void seed_mood(dvna_pkg::t_class c);
        int idx;
        idx      = (c >= NUM_ANCHORS) ? 0 : int'(c);
        mood_val = dvna_pkg::t_q15'(ANCH_V[idx]);
        mood_act = dvna_pkg::t_q15'(ANCH_A[idx]);
        mood_cls = dvna_pkg::t_class'(idx);
    endfunction

    function automatic t_mood_word predict_word(logic kind, logic [15:0] ms,
                                                dvna_pkg::t_event ev);
        int         keep;
        logic       moved;
        t_mood_word w;
        moved = 1'b0;
        if (kind == REQ_TICK) begin
            keep     = (int'(ms) >= SPAN) ? 0 : SPAN - int'(ms);
            mood_val = decay_q15(mood_val, keep);
            mood_act = decay_q15(mood_act, keep);
            moved    = reclassify();
        end else if (ev == WAKE_EVENT) begin
            mood_val = dvna_pkg::t_q15'(ANCH_V[0]);
            mood_act = dvna_pkg::t_q15'(ANCH_A[0]);
            mood_cls = '0;
        end else if (int'(ev) < NUM_EVENTS) begin
            mood_val = sat_q15(int'(mood_val) + STEP_V[ev]);
            mood_act = sat_q15(int'(mood_act) + STEP_A[ev]);
            moved    = reclassify();
        end
        w.cls     = mood_cls;
        w.changed = moved;
        w.val     = mood_val;
        w.act     = mood_act;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Idle pattern and mismatch reporting
    // ------------------------------------------------------------------

    // Random idle gap, with runs of no waiting at all now and then
    function automatic int unsigned pick_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic flag_error(input string what, input longint got, input longint want);
        err_count++;
        $display("ERROR word %0d, %s: got %0d, expected %0d", words_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result side: hold off at random, compare every accepted word
    // ------------------------------------------------------------------

    initial begin : result_sink
        int unsigned gap;
        bit          burst;
        burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = pick_gap(burst);
            // Take the long hold-off once when asked, so the block backs up
            if (hold_results) begin
                gap          = LONG_HOLD;
                hold_results = 1'b0;
            end
            repeat (gap) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_mood_word want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            words_seen++;
            if (mood_expected.size() == 0) begin
                flag_error("word with nothing expected, class", rsp_if.class_index, -1);
            end else begin
                want = mood_expected.pop_front();
                if (rsp_if.class_index !== want.cls)
                    flag_error("class_index", rsp_if.class_index, want.cls);
                if (rsp_if.class_changed !== want.changed)
                    flag_error("class_changed", rsp_if.class_changed, want.changed);
                if (rsp_if.valence_out !== want.val)
                    flag_error("valence_out", longint'(rsp_if.valence_out),
                               longint'(want.val));
                if (rsp_if.activation_out !== want.act)
                    flag_error("activation_out", longint'(rsp_if.activation_out),
                               longint'(want.act));
            end
        end
    end

    // Watchdog: end the run when no channel has moved a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one word after a random gap; leave valid high so a gap-free next word
    // follows without a bubble. Predict at the edge that accepts it.
    task automatic send_word(input logic kind, input logic [15:0] ms,
                             input dvna_pkg::t_event ev,
                             input logic known, input t_mood_word want);
        int unsigned gap;
        t_mood_word  pred;
        gap = tx_flood ? 0 : pick_gap(tx_burst);
        if (gap != 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.elapsed_ms <= ms;
        req_if.event_code <= ev;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        pred = predict_word(kind, ms, ev);
        mood_expected.push_back(known ? want : pred);
    endtask

    // Drop valid, wait for every expected word, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (mood_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_initial_class(input dvna_pkg::t_class c);
        @(negedge i_clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.initial_class <= c;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        seed_mood(c);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly ticks with short elapsed times and valid events; now and then a
    // saturating tick, a tick near the window edge, a wake or an ignored code.
    // Ignored codes do not count toward the total.
    task automatic run_random(input int words);
        int               applied;
        int unsigned      pick;
        logic             kind;
        logic [15:0]      ms;
        dvna_pkg::t_event ev;
        applied = 0;
        while (applied < words) begin
            kind = ($urandom_range(0, 9) < 4) ? REQ_TICK : REQ_EVENT;
            pick = $urandom_range(0, 15);
            if (pick == 0)      ms = 16'($urandom_range(0, 65535));
            else if (pick == 1) ms = 16'($urandom_range(SPAN, 65535));
            else if (pick == 2) ms = 16'($urandom_range(SPAN - 10, SPAN + 10));
            else                ms = 16'($urandom_range(0, 1500));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                ev = dvna_pkg::t_event'($urandom_range(NUM_EVENTS, EV_IGNORED_HI));
            else if (pick == 1)
                ev = WAKE_EVENT;
            else
                ev = dvna_pkg::t_event'($urandom_range(0, NUM_EVENTS - 1));
            send_word(kind, ms, ev, PREDICT, REST);
            if (!(kind == REQ_EVENT && int'(ev) >= NUM_EVENTS)) applied++;
        end
    endtask

    // Pressure: receiver holds off while the sender keeps offering words
    task automatic squeeze();
        hold_results = 1'b1;
        tx_flood     = 1'b1;
        run_random(8);
        tx_flood     = 1'b0;
    endtask

    initial begin : stimulus
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_TICK;
        req_if.elapsed_ms    = '0;
        req_if.event_code    = '0;
        rsp_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.initial_class = '0;
        i_rst_n              = 1'b0;
        seed_mood('0);

        // Hold reset low from time zero, then release it at a falling edge
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].kind, DIRECTED[i].ms, DIRECTED[i].ev,
                      DIRECTED[i].known, DIRECTED[i].want);
        settle();

        // Each phase re-seeds from a new initial class, written only while idle
        foreach (CLASS_PLAN[p]) begin
            write_initial_class(CLASS_PLAN[p]);
            if (p == 1 || p == 7) squeeze();
            run_random(WORDS_PER_PHASE);
            settle();
        end

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
sv/dvna_pkg.sv
sv/dvna_req_if.sv
sv/dvna_rsp_if.sv
sv/dvna_cfg_if.sv
sv/dvna_mul.sv
sv/decaying_vector_nearest_anchor.sv
sv/dvna_chk.sv
sim/tb_decaying_vector_nearest_anchor.sv
